FILE: hdl/wodt_pkg.sv
package wodt_pkg;

    // default sizes
    localparam int WIRE_COUNT_DEF    = 4096;
    localparam int OP_INDEX_BITS_DEF = 16;
    localparam int CALL_SPAN_DEF     = 32;
    localparam int MAX_SPAN_DEF      = 32;

    // beat field widths
    localparam int CMD_W  = 4;
    localparam int OP_W   = 16;
    localparam int WIRE_W = 12;
    localparam int SPAN_W = 13;

    // command codes
    localparam logic [CMD_W-1:0] CMD_TWO_SRC    = 4'd0;
    localparam logic [CMD_W-1:0] CMD_REWRITE    = 4'd1;
    localparam logic [CMD_W-1:0] CMD_COPY       = 4'd2;
    localparam logic [CMD_W-1:0] CMD_COPY_INDIR = 4'd3;
    localparam logic [CMD_W-1:0] CMD_INDIR_COPY = 4'd4;
    localparam logic [CMD_W-1:0] CMD_CLEAR      = 4'd5;
    localparam logic [CMD_W-1:0] CMD_CLAIM_UP   = 4'd6;
    localparam logic [CMD_W-1:0] CMD_CLAIM_DOWN = 4'd7;
    localparam logic [CMD_W-1:0] CMD_BITS_DEST  = 4'd8;
    localparam logic [CMD_W-1:0] CMD_JOIN_SRC   = 4'd9;
    localparam logic [CMD_W-1:0] CMD_JOIN_DEST  = 4'd10;
    localparam logic [CMD_W-1:0] CMD_BRANCH     = 4'd11;

    // walk base select
    localparam logic [2:0] SRC_A    = 3'd0;
    localparam logic [2:0] SRC_B    = 3'd1;
    localparam logic [2:0] SRC_D    = 3'd2;
    localparam logic [2:0] SRC_ZERO = 3'd3;
    localparam logic [2:0] SRC_TGT  = 3'd4;
    localparam logic [2:0] SRC_NEXT = 3'd5;

    // walk length select
    localparam logic [1:0] LEN_ONE   = 2'd0;
    localparam logic [1:0] LEN_COPY  = 2'd1;
    localparam logic [1:0] LEN_CALL  = 2'd2;
    localparam logic [1:0] LEN_CLEAR = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [OP_W-1:0]   op_index;
        logic [WIRE_W-1:0] wire_a;
        logic [WIRE_W-1:0] wire_b;
        logic [WIRE_W-1:0] wire_dest;
        logic [SPAN_W-1:0] span;
        logic [OP_W-1:0]   target_op;
    } t_in_item;

    typedef struct packed {
        logic            edge_valid;
        logic [OP_W-1:0] pred_op;
        logic [OP_W-1:0] succ_op;
        logic            last;
    } t_out_item;

    // one pass of the sequencer over a run of wires
    typedef struct packed {
        logic       en;
        logic [2:0] src;
        logic [1:0] len;
        logic       down;
        logic       edge_en;
        logic       claim;
        logic       skip_self;
    } t_walk;

    function automatic t_walk mk_walk(input logic [2:0] src, input logic [1:0] len,
                                      input logic down, input logic edge_en,
                                      input logic claim, input logic skip_self);
        t_walk w;
        w.en        = 1'b1;
        w.src       = src;
        w.len       = len;
        w.down      = down;
        w.edge_en   = edge_en;
        w.claim     = claim;
        w.skip_self = skip_self;
        return w;
    endfunction

    // walk list per command, up to three walks
    function automatic t_walk walk_desc(input logic [CMD_W-1:0] cmd, input logic [1:0] phase);
        t_walk w;
        w = '0;
        unique case (cmd)
            CMD_TWO_SRC: begin
                if (phase == 2'd0) w = mk_walk(SRC_A, LEN_ONE, 1'b0, 1'b1, 1'b0, 1'b0);
                if (phase == 2'd1) w = mk_walk(SRC_B, LEN_ONE, 1'b0, 1'b1, 1'b0, 1'b0);
                if (phase == 2'd2) w = mk_walk(SRC_D, LEN_ONE, 1'b0, 1'b0, 1'b1, 1'b0);
            end
            CMD_REWRITE: begin
                if (phase == 2'd0) w = mk_walk(SRC_D, LEN_ONE, 1'b0, 1'b1, 1'b1, 1'b0);
            end
            CMD_COPY: begin
                if (phase == 2'd0) w = mk_walk(SRC_A, LEN_COPY, 1'b0, 1'b1, 1'b0, 1'b0);
                if (phase == 2'd1) w = mk_walk(SRC_D, LEN_COPY, 1'b0, 1'b1, 1'b1, 1'b0);
            end
            CMD_COPY_INDIR: begin
                if (phase == 2'd0) w = mk_walk(SRC_D, LEN_COPY, 1'b0, 1'b1, 1'b1, 1'b0);
            end
            CMD_INDIR_COPY: begin
                if (phase == 2'd0) w = mk_walk(SRC_A, LEN_COPY, 1'b0, 1'b1, 1'b0, 1'b0);
            end
            CMD_CLEAR: begin
                if (phase == 2'd0) w = mk_walk(SRC_ZERO, LEN_CLEAR, 1'b0, 1'b0, 1'b1, 1'b0);
            end
            CMD_CLAIM_UP: begin
                if (phase == 2'd0) w = mk_walk(SRC_D, LEN_CALL, 1'b0, 1'b0, 1'b1, 1'b0);
            end
            CMD_CLAIM_DOWN: begin
                if (phase == 2'd0) w = mk_walk(SRC_D, LEN_CALL, 1'b1, 1'b0, 1'b1, 1'b0);
            end
            CMD_BITS_DEST: begin
                if (phase == 2'd0) w = mk_walk(SRC_D, LEN_ONE, 1'b0, 1'b1, 1'b1, 1'b1);
            end
            CMD_JOIN_SRC: begin
                if (phase == 2'd0) w = mk_walk(SRC_A, LEN_ONE, 1'b0, 1'b1, 1'b1, 1'b0);
            end
            CMD_JOIN_DEST: begin
                if (phase == 2'd0) w = mk_walk(SRC_D, LEN_ONE, 1'b0, 1'b0, 1'b1, 1'b0);
            end
            CMD_BRANCH: begin
                if (phase == 2'd0) w = mk_walk(SRC_TGT, LEN_ONE, 1'b0, 1'b1, 1'b0, 1'b0);
                if (phase == 2'd1) w = mk_walk(SRC_NEXT, LEN_ONE, 1'b0, 1'b1, 1'b0, 1'b0);
                if (phase == 2'd2) w = mk_walk(SRC_A, LEN_ONE, 1'b0, 1'b1, 1'b1, 1'b0);
            end
            default: begin
                w = '0;
            end
        endcase
        return w;
    endfunction

endpackage

FILE: hdl/wire_owner_dependency_tracker.sv
// Last-writer dependency tracker. An owner table holds, per wire, a valid bit and the index
// of the operation that last claimed it. Each input beat is one operation; the block reads the
// owners of the wires the operation depends on, sends one edge beat (pred_op -> succ_op) per
// owned wire (a branch also sends edges from its target and next op), then claims the wires
// the operation writes. An operation that yields no edge sends one bare completion beat; the
// final beat of every operation has last set. After reset a clearing pass walks the whole
// table, one entry a cycle, with o_in_ready low. The single table port and a sequencer that
// runs the operation as up to three walks set the pace: a wire whose owner is looked up takes
// a read, then a check and claim; a wire that is only claimed takes one write; a base address
// above the table is folded in by subtracting WIRE_COUNT (never needed for WIRE_COUNT of 4096
// or more). o_in_ready is high only between operations; one output register plus one held
// edge let the sequencer run ahead of the sink.
module wire_owner_dependency_tracker #(
    parameter int WIRE_COUNT    = wodt_pkg::WIRE_COUNT_DEF,
    parameter int OP_INDEX_BITS = wodt_pkg::OP_INDEX_BITS_DEF,
    parameter int CALL_SPAN     = wodt_pkg::CALL_SPAN_DEF,
    parameter int MAX_SPAN      = wodt_pkg::MAX_SPAN_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  wodt_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output wodt_pkg::t_out_item o_out_data
);
    import wodt_pkg::*;

    // table address, walk counter and owner widths
    localparam int AW      = (WIRE_COUNT > 1) ? $clog2(WIRE_COUNT) : 1;
    localparam int RW      = (AW + 1 > WIRE_W) ? AW + 1 : WIRE_W;
    localparam int CW      = (AW + 1 > SPAN_W) ? AW + 1 : SPAN_W;
    localparam int OPW     = OP_INDEX_BITS;
    localparam int ENTRY_W = OPW + 1;

    localparam logic [RW-1:0] ADDR_LAST  = RW'(WIRE_COUNT - 1);
    localparam logic [RW-1:0] ADDR_COUNT = RW'(WIRE_COUNT);
    localparam logic [CW-1:0] CNT_ONE    = CW'(1);
    localparam logic [CW-1:0] CNT_COUNT  = CW'(WIRE_COUNT);
    localparam logic [CW-1:0] CNT_MAX    = CW'(MAX_SPAN);
    localparam logic [CW-1:0] CNT_CALL   = CW'(CALL_SPAN);

    // sequencer states
    localparam logic [3:0] S_INIT   = 4'd0;  // clearing pass
    localparam logic [3:0] S_IDLE   = 4'd1;  // waiting for an operation
    localparam logic [3:0] S_START  = 4'd2;  // load next walk
    localparam logic [3:0] S_WRAP   = 4'd3;  // fold base into table range
    localparam logic [3:0] S_READ   = 4'd4;  // table read
    localparam logic [3:0] S_USE    = 4'd5;  // owner check, edge, claim
    localparam logic [3:0] S_WRITE  = 4'd6;  // claim without lookup
    localparam logic [3:0] S_EDGE   = 4'd7;  // edge with a fixed predecessor
    localparam logic [3:0] S_FINISH = 4'd8;  // close out with last

    logic [3:0]         r_state, n_state;
    t_in_item           r_item, n_item;
    logic [1:0]         r_phase, n_phase;
    t_walk              r_walk, n_walk;
    logic [RW-1:0]      r_addr, n_addr;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic [ENTRY_W-1:0] r_rd;
    logic               r_hold_vld, n_hold_vld;
    logic [OP_W-1:0]    r_hold_pred, n_hold_pred;
    logic               r_out_vld, n_out_vld;
    t_out_item          r_out, n_out;

    // owner table: valid bit over operation index
    logic [ENTRY_W-1:0] r_mem [WIRE_COUNT];

    logic               w_we;
    logic               w_re;
    logic [ENTRY_W-1:0] w_wdata;

    logic [OPW-1:0]     w_op;
    logic [OPW-1:0]     w_next;
    logic [OPW-1:0]     w_tgt;
    logic [OP_W-1:0]    w_succ;
    t_walk              w_desc;
    logic [CW-1:0]      w_len;
    logic [RW-1:0]      w_base;
    logic [RW-1:0]      w_step;
    logic               w_hit;
    logic               w_out_free;
    logic               w_push_ok;
    logic               w_last_wire;
    logic               w_emit;
    logic [OP_W-1:0]    w_emit_pred;
    logic               w_fin;

    assign w_op   = OPW'(r_item.op_index);
    assign w_next = w_op + OPW'(1);
    assign w_tgt  = OPW'(r_item.target_op);
    assign w_succ = OP_W'(w_op);
    assign w_desc = walk_desc(r_item.command, r_phase);

    // number of wires in the walk about to start
    always_comb begin
        unique case (w_desc.len)
            LEN_ONE:   w_len = CNT_ONE;
            LEN_COPY:  w_len = (CW'(r_item.span) < CNT_MAX) ? CW'(r_item.span) : CNT_MAX;
            LEN_CALL:  w_len = CNT_CALL;
            LEN_CLEAR: w_len = (CW'(r_item.span) < CNT_COUNT) ? CW'(r_item.span) : CNT_COUNT;
            default:   w_len = CNT_ONE;
        endcase
    end

    always_comb begin
        unique case (w_desc.src)
            SRC_A:   w_base = RW'(r_item.wire_a);
            SRC_B:   w_base = RW'(r_item.wire_b);
            SRC_D:   w_base = RW'(r_item.wire_dest);
            default: w_base = '0;
        endcase
    end

    // next wire, wrapping within the table
    always_comb begin
        if (r_walk.down) begin
            w_step = (r_addr == '0) ? ADDR_LAST : r_addr - RW'(1);
        end else begin
            w_step = (r_addr == ADDR_LAST) ? '0 : r_addr + RW'(1);
        end
    end

    // an owner equal to this op is skipped for bits-dest lists
    assign w_hit = r_rd[OPW] && !(r_walk.skip_self && (r_rd[OPW-1:0] == w_op));

    assign w_out_free  = !r_out_vld || i_out_ready;
    assign w_push_ok   = !r_hold_vld || w_out_free;
    assign w_last_wire = (r_cnt == CNT_ONE);

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_phase     = r_phase;
        n_walk      = r_walk;
        n_addr      = r_addr;
        n_cnt       = r_cnt;
        w_we        = 1'b0;
        w_re        = 1'b0;
        w_wdata     = {1'b1, w_op};
        w_emit      = 1'b0;
        w_emit_pred = '0;
        w_fin       = 1'b0;

        unique case (r_state)
            S_INIT: begin
                w_we    = 1'b1;
                w_wdata = '0;
                if (r_addr == ADDR_LAST) begin
                    n_addr  = '0;
                    n_state = S_IDLE;
                end else begin
                    n_addr = r_addr + RW'(1);
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item  = i_in_data;
                    n_phase = '0;
                    n_state = S_START;
                end
            end
            S_START: begin
                if (!w_desc.en) begin
                    n_state = S_FINISH;
                end else begin
                    n_walk = w_desc;
                    n_cnt  = w_len;
                    n_addr = w_base;
                    if (w_len == '0) begin
                        // empty span, on to the next walk
                        n_phase = r_phase + 2'd1;
                    end else if (w_desc.src == SRC_TGT || w_desc.src == SRC_NEXT) begin
                        n_state = S_EDGE;
                    end else begin
                        n_state = S_WRAP;
                    end
                end
            end
            S_WRAP: begin
                priority if (r_addr >= ADDR_COUNT) begin
                    n_addr = r_addr - ADDR_COUNT;
                end else if (r_walk.down) begin
                    // claim-down starts one below the base
                    n_addr  = w_step;
                    n_state = S_WRITE;
                end else begin
                    n_state = r_walk.edge_en ? S_READ : S_WRITE;
                end
            end
            S_READ: begin
                w_re    = 1'b1;
                n_state = S_USE;
            end
            S_USE: begin
                if (!(w_hit && !w_push_ok)) begin
                    w_emit      = w_hit;
                    w_emit_pred = OP_W'(r_rd[OPW-1:0]);
                    w_we        = r_walk.claim;
                    if (w_last_wire) begin
                        n_phase = r_phase + 2'd1;
                        n_state = S_START;
                    end else begin
                        n_cnt   = r_cnt - CNT_ONE;
                        n_addr  = w_step;
                        n_state = S_READ;
                    end
                end
            end
            S_WRITE: begin
                w_we = 1'b1;
                if (w_last_wire) begin
                    n_phase = r_phase + 2'd1;
                    n_state = S_START;
                end else begin
                    n_cnt  = r_cnt - CNT_ONE;
                    n_addr = w_step;
                end
            end
            S_EDGE: begin
                if (w_push_ok) begin
                    w_emit      = 1'b1;
                    w_emit_pred = (r_walk.src == SRC_TGT) ? OP_W'(w_tgt) : OP_W'(w_next);
                    n_phase     = r_phase + 2'd1;
                    n_state     = S_START;
                end
            end
            S_FINISH: begin
                if (w_out_free) begin
                    w_fin   = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // held edge and output register: the newest edge waits in the hold slot until it is
    // known whether another edge follows, which decides its last flag
    always_comb begin
        n_out_vld   = r_out_vld && !i_out_ready;
        n_out       = r_out;
        n_hold_vld  = r_hold_vld;
        n_hold_pred = r_hold_pred;
        if (w_emit) begin
            if (r_hold_vld) begin
                n_out_vld = 1'b1;
                n_out     = '{edge_valid: 1'b1, pred_op: r_hold_pred, succ_op: w_succ,
                              last: 1'b0};
            end
            n_hold_vld  = 1'b1;
            n_hold_pred = w_emit_pred;
        end
        if (w_fin) begin
            n_out_vld = 1'b1;
            if (r_hold_vld) begin
                n_out = '{edge_valid: 1'b1, pred_op: r_hold_pred, succ_op: w_succ,
                          last: 1'b1};
            end else begin
                // no edge at all: bare completion beat
                n_out = '{edge_valid: 1'b0, pred_op: '0, succ_op: w_succ, last: 1'b1};
            end
            n_hold_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_INIT;
            r_phase    <= '0;
            r_addr     <= '0;
            r_cnt      <= '0;
            r_hold_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_phase    <= n_phase;
            r_addr     <= n_addr;
            r_cnt      <= n_cnt;
            r_hold_vld <= n_hold_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_item      <= n_item;
        r_walk      <= n_walk;
        r_hold_pred <= n_hold_pred;
        r_out       <= n_out;
    end

    // single-port table, registered read
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_addr[AW-1:0]] <= w_wdata;
        end
        if (w_re) begin
            r_rd <= r_mem[r_addr[AW-1:0]];
        end
    end

    // no edge left behind between operations
    a_hold_empty_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_hold_vld)
        else $error("held edge left over in idle");

    // a completion without an edge always closes its operation
    a_bare_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.edge_valid) |-> o_out_data.last)
        else $error("bare completion without last");

    // nothing leaves the block during the clearing pass
    a_init_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INIT) |-> (!o_out_valid && !r_hold_vld))
        else $error("output during clearing pass");

    // table reads and claims only after the base has been folded into range
    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ || r_state == S_WRITE) |-> (r_addr < ADDR_COUNT))
        else $error("table address out of range");

endmodule

FILE: sim/wire_owner_dependency_tracker_tb.sv
module wire_owner_dependency_tracker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wodt_pkg::*;

    // sizes the block is built with
    localparam int WIRES      = WIRE_COUNT_DEF;
    localparam int CALL_WIRES = CALL_SPAN_DEF;
    localparam int COPY_LIMIT = MAX_SPAN_DEF;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_data;

    wire_owner_dependency_tracker DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow copy of the owner table
    logic            wire_owned [WIRES];
    logic [OP_W-1:0] wire_owner [WIRES];

    // result beats still to come, oldest first
    t_out_item       pending_results[$];
    // predecessors found for the operation being predicted
    logic [OP_W-1:0] found_preds[$];

    // idling knobs, percent per cycle
    int in_idle_pct   = 0;
    int out_stall_pct = 0;

    // running operation index for the random traffic
    logic [OP_W-1:0] op_counter = '0;

    int errors        = 0;
    int ops_sent      = 0;
    int beats_checked = 0;
    int edges_seen    = 0;
    int cmd_seen [16];

    // ------------------------------------------------------------------
    // dependency prediction
    // ------------------------------------------------------------------

    // edge from the current owner of a wire, if it has one
    function automatic void note_owner(input logic [WIRE_W-1:0] w);
        if (wire_owned[w])
            found_preds = {found_preds, wire_owner[w]};
    endfunction

    function automatic void take_wire(input logic [WIRE_W-1:0] w, input logic [OP_W-1:0] op);
        wire_owned[w] = 1'b1;
        wire_owner[w] = op;
    endfunction

    // reads owners, claims wires, and queues the beats this operation must produce
    function automatic void predict_dependencies(input t_in_item it);
        int              n_copy;
        int              n_clear;
        logic [WIRE_W-1:0] w;
        logic [OP_W-1:0]   op;
        t_out_item       beat;

        op = it.op_index;
        found_preds.delete();
        n_copy  = (it.span < COPY_LIMIT) ? int'(it.span) : COPY_LIMIT;
        n_clear = (it.span < WIRES) ? int'(it.span) : WIRES;
        cmd_seen[it.command]++;

        case (it.command)
            CMD_TWO_SRC: begin
                note_owner(it.wire_a);
                note_owner(it.wire_b);
                take_wire(it.wire_dest, op);
            end
            CMD_REWRITE: begin
                note_owner(it.wire_dest);
                take_wire(it.wire_dest, op);
            end
            CMD_COPY: begin
                // all source reads come before any destination claim
                for (int i = 0; i < n_copy; i++) begin
                    w = WIRE_W'(it.wire_a + i);
                    note_owner(w);
                end
                for (int i = 0; i < n_copy; i++) begin
                    w = WIRE_W'(it.wire_dest + i);
                    note_owner(w);
                    take_wire(w, op);
                end
            end
            CMD_COPY_INDIR: begin
                for (int i = 0; i < n_copy; i++) begin
                    w = WIRE_W'(it.wire_dest + i);
                    note_owner(w);
                    take_wire(w, op);
                end
            end
            CMD_INDIR_COPY: begin
                for (int i = 0; i < n_copy; i++) begin
                    w = WIRE_W'(it.wire_a + i);
                    note_owner(w);
                end
            end
            CMD_CLEAR: begin
                for (int i = 0; i < n_clear; i++) begin
                    w = WIRE_W'(i);
                    take_wire(w, op);
                end
            end
            CMD_CLAIM_UP: begin
                for (int i = 0; i < CALL_WIRES; i++) begin
                    w = WIRE_W'(it.wire_dest + i);
                    take_wire(w, op);
                end
            end
            CMD_CLAIM_DOWN: begin
                // span sits just below the base, wrapping past wire 0
                for (int i = 0; i < CALL_WIRES; i++) begin
                    w = WIRE_W'(it.wire_dest - i - 1);
                    take_wire(w, op);
                end
            end
            CMD_BITS_DEST: begin
                // a wire already claimed by this same list gives no edge
                if (wire_owned[it.wire_dest] && wire_owner[it.wire_dest] != op)
                    found_preds = {found_preds, wire_owner[it.wire_dest]};
                take_wire(it.wire_dest, op);
            end
            CMD_JOIN_SRC: begin
                note_owner(it.wire_a);
                take_wire(it.wire_a, op);
            end
            CMD_JOIN_DEST: begin
                take_wire(it.wire_dest, op);
            end
            CMD_BRANCH: begin
                // label target, fall-through successor, then the condition wire
                found_preds = {found_preds, it.target_op};
                found_preds = {found_preds, op + 16'd1};
                note_owner(it.wire_a);
                take_wire(it.wire_a, op);
            end
            default: begin
                // unknown code leaves the table alone
            end
        endcase

        if (found_preds.size() > 64)
            found_preds = found_preds[0:63];

        if (found_preds.size() == 0) begin
            // bare completion
            beat.edge_valid = 1'b0;
            beat.pred_op    = '0;
            beat.succ_op    = op;
            beat.last       = 1'b1;
            pending_results = {pending_results, beat};
        end else begin
            foreach (found_preds[k]) begin
                beat.edge_valid = 1'b1;
                beat.pred_op    = found_preds[k];
                beat.succ_op    = op;
                beat.last       = (k == found_preds.size() - 1);
                pending_results = {pending_results, beat};
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------

    function automatic void compare_field(input string name, input logic [OP_W-1:0] want,
                                          input logic [OP_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            errors++;
        end
    endfunction

    function automatic void check_result_beat(input t_out_item got);
        t_out_item want;
        if (pending_results.size() == 0) begin
            $display("%0t: unexpected result beat edge_valid=%0b pred_op=%h succ_op=%h last=%0b",
                     $time, got.edge_valid, got.pred_op, got.succ_op, got.last);
            errors++;
            return;
        end
        want = pending_results.pop_front();
        beats_checked++;
        if (got.edge_valid === 1'b1)
            edges_seen++;
        compare_field("edge_valid", OP_W'(want.edge_valid), OP_W'(got.edge_valid));
        compare_field("pred_op", want.pred_op, got.pred_op);
        compare_field("succ_op", want.succ_op, got.succ_op);
        compare_field("last", OP_W'(want.last), OP_W'(got.last));
    endfunction

    // sample the output beat, then pick the next ready value
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            check_result_beat(o_out_data);
        i_out_ready <= ($urandom_range(99) >= out_stall_pct);
    end

    // ------------------------------------------------------------------
    // sending side
    // ------------------------------------------------------------------

    // called at a rising edge; returns at the edge where the beat is taken
    task automatic send_beat(input t_in_item it);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do
            @(posedge i_clk);
        while (!(i_in_valid === 1'b1 && o_in_ready === 1'b1));
        predict_dependencies(it);
        ops_sent++;
    endtask

    // hold off the sender until every expected beat is back, then let the block settle
    task automatic wait_drained(input int settle);
        i_in_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (pending_results.size() != 0);
        repeat (settle) @(posedge i_clk);
    endtask

    function automatic t_in_item make_item(input logic [CMD_W-1:0] cmd,
                                           input logic [OP_W-1:0] op,
                                           input logic [WIRE_W-1:0] wa,
                                           input logic [WIRE_W-1:0] wb,
                                           input logic [WIRE_W-1:0] wd,
                                           input logic [SPAN_W-1:0] span,
                                           input logic [OP_W-1:0] tgt);
        t_in_item it;
        it.command   = cmd;
        it.op_index  = op;
        it.wire_a    = wa;
        it.wire_b    = wb;
        it.wire_dest = wd;
        it.span      = span;
        it.target_op = tgt;
        return it;
    endfunction

    // mostly a small pool so owners collide, some near the top to wrap, some anywhere
    function automatic logic [WIRE_W-1:0] pick_wire();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return WIRE_W'($urandom_range(63));
        else if (r < 80)
            return WIRE_W'($urandom_range(WIRES - 1, WIRES - 64));
        else
            return WIRE_W'($urandom_range(WIRES - 1));
    endfunction

    // mostly consecutive operation indices, now and then a jump
    function automatic logic [OP_W-1:0] next_op();
        if ($urandom_range(19) == 0)
            op_counter = OP_W'($urandom);
        else
            op_counter = op_counter + 16'd1;
        return op_counter;
    endfunction

    function automatic t_in_item random_op(input logic [CMD_W-1:0] cmd,
                                           input logic [OP_W-1:0] op);
        t_in_item it;
        it.command   = cmd;
        it.op_index  = op;
        it.wire_a    = pick_wire();
        it.wire_b    = pick_wire();
        it.wire_dest = pick_wire();
        it.target_op = OP_W'($urandom);
        // copies mostly near the clamp, now and then any length
        if ($urandom_range(99) < 85)
            it.span = SPAN_W'($urandom_range(40));
        else
            it.span = SPAN_W'($urandom_range(WIRES));
        // full-table clears are slow, keep them rare
        if (cmd == CMD_CLEAR)
            it.span = ($urandom_range(9) == 0) ? SPAN_W'($urandom_range(WIRES))
                                               : SPAN_W'($urandom_range(64));
        return it;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // empty table: no edges, then owners found; field extremes
    task automatic test_unowned_and_owned();
        send_beat(make_item(CMD_TWO_SRC, 16'd0, 12'd0, 12'd4095, 12'd0, 13'd0, 16'd0));
        send_beat(make_item(CMD_REWRITE, 16'd1, 12'd4095, 12'd0, 12'd0, 13'd4096, 16'hFFFF));
        send_beat(make_item(CMD_TWO_SRC, 16'd2, 12'd0, 12'd0, 12'd4095, 13'd1, 16'd0));
    endtask

    // copy spans that wrap past the top of the table and spans above the clamp
    task automatic test_copy_wrap_and_clamp();
        send_beat(make_item(CMD_COPY, 16'd3, 12'd4090, 12'd0, 12'd100, 13'd8, 16'd0));
        send_beat(make_item(CMD_COPY, 16'd4, 12'd100, 12'd0, 12'd4080, 13'd4096, 16'd0));
        send_beat(make_item(CMD_COPY_INDIR, 16'd5, 12'd0, 12'd0, 12'd4080, 13'd40, 16'd0));
        send_beat(make_item(CMD_INDIR_COPY, 16'd6, 12'd4064, 12'd0, 12'd0, 13'd0, 16'd0));
        send_beat(make_item(CMD_INDIR_COPY, 16'd7, 12'd4070, 12'd0, 12'd0, 13'd33, 16'd0));
    endtask

    // whole-table clear, empty clear, call spans wrapping both ways
    task automatic test_bulk_claims();
        send_beat(make_item(CMD_CLEAR, 16'd8, 12'd0, 12'd0, 12'd0, 13'd4096, 16'd0));
        send_beat(make_item(CMD_CLEAR, 16'd9, 12'd0, 12'd0, 12'd0, 13'd0, 16'd0));
        send_beat(make_item(CMD_CLAIM_UP, 16'hFFFF, 12'd0, 12'd0, 12'd4080, 13'd0, 16'd0));
        send_beat(make_item(CMD_CLAIM_DOWN, 16'd10, 12'd0, 12'd0, 12'd5, 13'd0, 16'd0));
    endtask

    // list elements, including a bits destination repeated within its own list
    task automatic test_list_elements();
        send_beat(make_item(CMD_BITS_DEST, 16'd11, 12'd0, 12'd0, 12'd200, 13'd0, 16'd0));
        send_beat(make_item(CMD_BITS_DEST, 16'd11, 12'd0, 12'd0, 12'd200, 13'd0, 16'd0));
        send_beat(make_item(CMD_BITS_DEST, 16'd11, 12'd0, 12'd0, 12'd201, 13'd0, 16'd0));
        send_beat(make_item(CMD_JOIN_SRC, 16'd12, 12'd200, 12'd0, 12'd0, 13'd0, 16'd0));
        send_beat(make_item(CMD_JOIN_DEST, 16'd12, 12'd0, 12'd0, 12'd4095, 13'd0, 16'd0));
    endtask

    // branch from the last index wraps its successor to zero
    task automatic test_branch();
        send_beat(make_item(CMD_BRANCH, 16'hFFFF, 12'd4095, 12'd0, 12'd0, 13'd0, 16'd0));
        send_beat(make_item(CMD_BRANCH, 16'd13, 12'd300, 12'hFFF, 12'hFFF, 13'h1FFF, 16'hFFFF));
    endtask

    // codes past the last command only complete
    task automatic test_unknown_commands();
        for (int c = CMD_BRANCH + 1; c < 16; c++)
            send_beat(make_item(CMD_W'(c), OP_W'(14 + c), 12'd4095, 12'd4095, 12'd4095,
                                13'd4096, 16'hFFFF));
    endtask

    // well-formed lists with random content, mixed with single operations and noise
    task automatic test_random_traffic(input int n_items, input int in_pct, input int out_pct);
        int              sent;
        int              r;
        int              k;
        logic [OP_W-1:0]   op;
        logic [WIRE_W-1:0] shared_w;
        t_in_item        it;

        in_idle_pct   = in_pct;
        out_stall_pct = out_pct;
        sent = 0;
        while (sent < n_items) begin
            op = next_op();
            r  = $urandom_range(99);
            if (r < 14) begin
                // bits destination list, wires often repeated
                k = $urandom_range(6, 1);
                shared_w = pick_wire();
                for (int j = 0; j < k; j++) begin
                    it = random_op(CMD_BITS_DEST, op);
                    if ($urandom_range(1))
                        it.wire_dest = shared_w;
                    send_beat(it);
                    sent++;
                end
            end else if (r < 26) begin
                // join: source elements, then the destination
                k = $urandom_range(4, 1);
                for (int j = 0; j < k; j++) begin
                    send_beat(random_op(CMD_JOIN_SRC, op));
                    sent++;
                end
                send_beat(random_op(CMD_JOIN_DEST, op));
                sent++;
            end else if (r < 29) begin
                // noise: unknown code
                send_beat(random_op(CMD_W'($urandom_range(15, CMD_BRANCH + 1)), op));
                sent++;
            end else begin
                send_beat(random_op(CMD_W'($urandom_range(CMD_BRANCH)), op));
                sent++;
            end
        end
    endtask

    function automatic int count_codes();
        int n;
        n = 0;
        foreach (cmd_seen[c])
            if (cmd_seen[c] != 0)
                n++;
        return n;
    endfunction

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_out_ready <= 1'b0;
        foreach (cmd_seen[c])
            cmd_seen[c] = 0;
        foreach (wire_owned[w]) begin
            wire_owned[w] = 1'b0;
            wire_owner[w] = '0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part at full rate on both sides
        test_unowned_and_owned();
        test_copy_wrap_and_clamp();
        test_bulk_claims();
        test_list_elements();
        test_branch();
        test_unknown_commands();
        wait_drained(20);

        // random part; the sender drains fully between phases
        test_random_traffic(30, 0, 0);
        wait_drained(20);
        test_random_traffic(30, 65, 0);
        wait_drained(20);
        test_random_traffic(30, 0, 65);
        wait_drained(20);
        test_random_traffic(30, 37, 37);
        wait_drained(200);

        $display("run covered %0d operations over %0d distinct command codes",
                 ops_sent, count_codes());
        $display("checked %0d result beats, %0d of them dependency edges, %0d errors",
                 beats_checked, edges_seen, errors);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // watchdog, well above the slowest legal run
    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
